[design/cfc_pkg.sv]
`timescale 1ns / 1ps

package cfc_pkg;

   // crc-16, reflected polynomial, no final xor
   localparam logic [15:0] CrcPoly = 16'hA001;
   localparam logic [15:0] CrcInit = 16'hFFFF;

   localparam logic [7:0] StationAddrReset = 8'hFE;

   // command codes that select the frame kind
   localparam logic [7:0] StatusReqCode = 8'h23;
   localparam logic [7:0] CommandCode   = 8'h24;

   // frame kind codes on the result
   localparam logic [1:0] KindStatus  = 2'd0;
   localparam logic [1:0] KindCommand = 2'd1;
   localparam logic [1:0] KindOther   = 2'd2;

   // frame positions before the payload
   localparam logic [8:0] IdxAddress = 9'd1;
   localparam logic [8:0] IdxCommand = 9'd2;
   localparam logic [8:0] IdxLength  = 9'd3;
   localparam logic [8:0] HeaderLen  = 9'd4;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       first_byte;
   } req_payload_type;

   typedef struct packed {
      logic        crc_match;
      logic        address_match;
      logic        frame_valid;
      logic [1:0]  frame_kind;
      logic [15:0] computed_crc;
   } rsp_payload_type;

   // what one byte step hands back to the top level
   typedef struct packed {
      logic            emit;
      rsp_payload_type payload;
   } step_result_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

[design/cfc_ifs.sv]
`timescale 1ns / 1ps

interface cfc_req_if;
   import cfc_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface cfc_rsp_if;
   import cfc_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface cfc_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[design/cfc_frame_state.sv]
`timescale 1ns / 1ps

module cfc_frame_state import cfc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  req_payload_type beat,
   input  logic [7:0]      station_address,
   output step_result_type result
);

   logic [15:0] crc_accum_ff, crc_accum_in;
   logic [8:0]  byte_index_ff, byte_index_in;
   logic [7:0]  payload_length_ff, payload_length_in;
   logic        address_seen_ok_ff, address_seen_ok_in;
   logic [7:0]  command_code_ff, command_code_in;
   logic [7:0]  received_crc_low_ff, received_crc_low_in;

   // state as seen by this beat, after a possible restart
   logic [15:0] crc_eff;
   logic [8:0]  idx_eff;
   logic [7:0]  len_eff;
   logic        addr_eff;
   logic [7:0]  cmd_eff;
   logic [7:0]  low_eff;
   logic [8:0]  crc_end;
   logic [15:0] rx_crc;
   logic        crc_ok;

   always_comb begin
      if (beat.first_byte) begin
         crc_eff  = CrcInit;
         idx_eff  = '0;
         len_eff  = '0;
         addr_eff = 1'b0;
         cmd_eff  = '0;
         low_eff  = '0;
      end else begin
         crc_eff  = crc_accum_ff;
         idx_eff  = byte_index_ff;
         len_eff  = payload_length_ff;
         addr_eff = address_seen_ok_ff;
         cmd_eff  = command_code_ff;
         low_eff  = received_crc_low_ff;
      end

      if (idx_eff == IdxAddress) begin
         addr_eff = (beat.rx_byte == station_address);
      end
      if (idx_eff == IdxCommand) begin
         cmd_eff = beat.rx_byte;
      end
      if (idx_eff == IdxLength) begin
         len_eff = beat.rx_byte;
      end

      crc_end = {1'b0, len_eff} + HeaderLen;
      rx_crc  = {beat.rx_byte, received_crc_low_ff};
      crc_ok  = (rx_crc == crc_accum_ff);

      crc_accum_in        = crc_eff;
      byte_index_in       = idx_eff + 9'd1;
      payload_length_in   = len_eff;
      address_seen_ok_in  = addr_eff;
      command_code_in     = cmd_eff;
      received_crc_low_in = low_eff;

      result.emit                  = 1'b0;
      result.payload.crc_match     = crc_ok;
      result.payload.address_match = address_seen_ok_ff;
      result.payload.frame_valid   = crc_ok & address_seen_ok_ff;
      result.payload.computed_crc  = crc_accum_ff;
      priority if (command_code_ff == StatusReqCode) begin
         result.payload.frame_kind = KindStatus;
      end else if (command_code_ff == CommandCode) begin
         result.payload.frame_kind = KindCommand;
      end else begin
         result.payload.frame_kind = KindOther;
      end

      priority if (idx_eff <= IdxLength || idx_eff < crc_end) begin
         crc_accum_in = crc_byte(crc_eff, beat.rx_byte);
      end else if (idx_eff == crc_end) begin
         received_crc_low_in = beat.rx_byte;
      end else begin
         // high crc byte closes the frame; a last byte never carries the start flag
         result.emit         = 1'b1;
         crc_accum_in        = CrcInit;
         byte_index_in       = '0;
         payload_length_in   = '0;
         address_seen_ok_in  = 1'b0;
         command_code_in     = '0;
         received_crc_low_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_accum_ff        <= CrcInit;
         byte_index_ff       <= '0;
         payload_length_ff   <= '0;
         address_seen_ok_ff  <= 1'b0;
         command_code_ff     <= '0;
         received_crc_low_ff <= '0;
      end else if (step) begin
         crc_accum_ff        <= crc_accum_in;
         byte_index_ff       <= byte_index_in;
         payload_length_ff   <= payload_length_in;
         address_seen_ok_ff  <= address_seen_ok_in;
         command_code_ff     <= command_code_in;
         received_crc_low_ff <= received_crc_low_in;
      end
   end

endmodule

[design/crc16_frame_checker.sv]
`timescale 1ns / 1ps

// channel | direction | beat carries
// req     | in        | rx_byte, first_byte
// rsp     | out       | crc_match, address_match, frame_valid, frame_kind, computed_crc
// csr     | in        | station_address (8 bits, reset 0xFE)
//
// one byte per cycle while rsp is not stalled; a byte waits in the input register and
// its result, if any, is registered into the output register when the byte is stepped
// the unrolled eight-bit crc step between the two registers sets the cycle time
// reset is synchronous and rearms the checker; the next byte is taken as byte 0
// a stalled rsp only holds req back when the waiting byte closes a frame
// csr is always ready

module crc16_frame_checker import cfc_pkg::*; (
   input logic      clock,
   input logic      reset,
   cfc_req_if.sink  req,
   cfc_rsp_if.source rsp,
   cfc_csr_if.sink  csr
);

   // input register
   logic            in_valid_ff;
   req_payload_type in_data_ff;

   // output register
   logic            out_valid_ff;
   rsp_payload_type out_data_ff;

   logic [7:0] station_address_ff;

   step_result_type step_res;
   logic            out_free;
   logic            step;
   logic            in_take;

   // result slot is free when empty or being drained this cycle
   assign out_free = !out_valid_ff || rsp.ready;
   // a byte with no result never waits on the output side
   assign step     = in_valid_ff && (!step_res.emit || out_free);
   assign in_take  = !in_valid_ff || step;

   assign req.ready = in_take;
   assign csr.ready = 1'b1;
   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_data_ff;

   cfc_frame_state u_state (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .beat            (in_data_ff),
      .station_address (station_address_ff),
      .result          (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_take) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take && req.valid) begin
         in_data_ff <= req.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step && step_res.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && step_res.emit) begin
         out_data_ff <= step_res.payload;
      end
   end

   // station address register
   always_ff @(posedge clock) begin
      if (reset) begin
         station_address_ff <= StationAddrReset;
      end else if (csr.valid) begin
         station_address_ff <= csr.data;
      end
   end

endmodule
